// ----- sv/ptpa_pkg.sv -----
// Types and constants shared by the position table proximity alert block.
package ptpa_pkg;

    localparam int ID_W  = 16;
    localparam int LAT_W = 31;
    localparam int LON_W = 32;
    localparam int SPD_W = 32;
    localparam int BAT_W = 10;
    localparam int RAD_W = 24;
    localparam int CFG_W = 32;
    localparam int CAP_W = RAD_W + 1;
    localparam int LIM_W = 2 * RAD_W;
    localparam int SQ_W  = 2 * CAP_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_WRITE,
        ST_PAIRS
    } state_t;

    typedef enum logic [1:0] {
        STATUS_INSERTED = 2'd0,
        STATUS_UPDATED  = 2'd1,
        STATUS_DROPPED  = 2'd2,
        STATUS_FILTERED = 2'd3
    } status_t;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_PAIR   = 1'b1;

    localparam logic [1:0] CFG_RADIUS      = 2'd0;
    localparam logic [1:0] CFG_MIN_SPEED   = 2'd1;
    localparam logic [1:0] CFG_LOW_BATTERY = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [LAT_W-1:0] lat;
        logic [LON_W-1:0] lon;
    } entry_t;

    typedef struct packed {
        logic [ID_W-1:0] lo;
        logic [ID_W-1:0] hi;
    } id_pair_t;

    typedef struct packed {
        logic            kind;
        status_t         status;
        logic            low_battery;
        logic [ID_W-1:0] first_id;
        logic [ID_W-1:0] second_id;
    } result_t;

endpackage

// ----- sv/position_table_proximity_alert.sv -----
// Position table with slot search, update and pairwise proximity scan.
// A filtered report gives its single status transfer in the cycle after start.
// Otherwise busy holds through the search over the occupied slots, the update, the issue
// of each slot pair after the update and the distance pipeline.
// Throughput is set by the two-read-port slot memory: one pair checked per cycle.
// Reset clears the slot count and the control registers; results cannot be held off by the receiver.
module position_table_proximity_alert #(
    parameter int SLOTS = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [ptpa_pkg::ID_W-1:0]     vehicle_id,
    input  logic signed [ptpa_pkg::LAT_W-1:0] latitude,
    input  logic signed [ptpa_pkg::LON_W-1:0] longitude,
    input  logic [ptpa_pkg::SPD_W-1:0]    speed,
    input  logic [ptpa_pkg::BAT_W-1:0]    battery,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [ptpa_pkg::CFG_W-1:0]    cfg_data,
    output logic                          strobe,
    output logic                          result_kind,
    output logic [1:0]                    status,
    output logic                          low_battery,
    output logic [ptpa_pkg::ID_W-1:0]     first_id,
    output logic [ptpa_pkg::ID_W-1:0]     second_id,
    output logic                          last
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam logic [CNT_W:0] SLOTS_C = (CNT_W + 1)'(SLOTS);

    // configuration
    logic [ptpa_pkg::RAD_W-1:0] radius_reg;
    logic [ptpa_pkg::SPD_W-1:0] min_speed_reg;
    logic [ptpa_pkg::BAT_W-1:0] low_level_reg;

    // slot memory
    ptpa_pkg::entry_t mem [SLOTS];
    ptpa_pkg::entry_t rd_a_reg, rd_b_reg;
    logic [SLOT_W-1:0] addr_a, addr_b, wr_addr;
    logic              wr_en;
    ptpa_pkg::entry_t  wr_data;

    // control
    ptpa_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] scan_reg, scan_next;
    logic             chk_v_reg, chk_v_next;
    logic [SLOT_W-1:0] chk_idx_reg, chk_idx_next;
    logic [SLOT_W-1:0] wslot_reg, wslot_next;
    logic [CNT_W-1:0] pi_reg, pi_next, pj_reg, pj_next;
    logic             issue_done_reg, issue_done_next;

    // item payload
    logic [ptpa_pkg::ID_W-1:0]  id_reg, id_next;
    logic [ptpa_pkg::LAT_W-1:0] lat_reg, lat_next;
    logic [ptpa_pkg::LON_W-1:0] lon_reg, lon_next;
    logic [ptpa_pkg::CAP_W-1:0] cap_reg, cap_next;
    logic [ptpa_pkg::LIM_W-1:0] lim_reg, lim_next;

    // distance pipeline
    logic v1_reg, v1_next, v2_reg, v2_next, v3_reg, v3_next;
    logic v4_reg, v4_next, v5_reg, v5_next;
    ptpa_pkg::id_pair_t idp2_reg, idp2_next, idp3_reg, idp3_next;
    ptpa_pkg::id_pair_t idp4_reg, idp4_next, idp5_reg, idp5_next;
    logic [31:0] dlat_reg, dlat_next, mlat_reg, mlat_next;
    logic [32:0] dlon_reg, dlon_next, mlon_reg, mlon_next;
    logic [ptpa_pkg::CAP_W-1:0] clat_reg, clat_next, clon_reg, clon_next;
    logic [ptpa_pkg::SQ_W-1:0]  sqlat_reg, sqlat_next, sqlon_reg, sqlon_next;
    logic [ptpa_pkg::SQ_W:0]    dist_sum;
    logic                       hit;

    // results
    ptpa_pkg::result_t pend_reg, pend_next;
    ptpa_pkg::result_t out_reg, out_next;
    logic              strobe_reg, strobe_next;
    logic              last_reg, last_next;

    logic [CNT_W:0] pj_inc, pi_inc2;
    logic           id_match;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg    <= ptpa_pkg::RAD_W'(50000);
            min_speed_reg <= ptpa_pkg::SPD_W'(10);
            low_level_reg <= ptpa_pkg::BAT_W'(200);
        end
        else if (cfg_we)
        begin
            if (cfg_index == ptpa_pkg::CFG_RADIUS)
                radius_reg <= cfg_data[ptpa_pkg::RAD_W-1:0];
            else if (cfg_index == ptpa_pkg::CFG_MIN_SPEED)
                min_speed_reg <= cfg_data[ptpa_pkg::SPD_W-1:0];
            else if (cfg_index == ptpa_pkg::CFG_LOW_BATTERY)
                low_level_reg <= cfg_data[ptpa_pkg::BAT_W-1:0];
        end
    end

    // slot memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_a_reg <= mem[addr_a];
        rd_b_reg <= mem[addr_b];
    end

    assign id_match = (rd_a_reg.id == id_reg);
    assign pj_inc   = {1'b0, pj_reg} + 1'b1;
    assign pi_inc2  = {1'b0, pi_reg} + 2'd2;
    assign dist_sum = {1'b0, sqlat_reg} + {1'b0, sqlon_reg};
    assign hit      = v5_reg && (dist_sum < (ptpa_pkg::SQ_W + 1)'(lim_reg));

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        scan_next       = scan_reg;
        chk_v_next      = 1'b0;
        chk_idx_next    = chk_idx_reg;
        wslot_next      = wslot_reg;
        pi_next         = pi_reg;
        pj_next         = pj_reg;
        issue_done_next = issue_done_reg;
        id_next         = id_reg;
        lat_next        = lat_reg;
        lon_next        = lon_reg;
        cap_next        = cap_reg;
        lim_next        = lim_reg;
        pend_next       = pend_reg;
        out_next        = out_reg;
        last_next       = last_reg;
        strobe_next     = 1'b0;
        addr_a          = '0;
        addr_b          = '0;
        wr_en           = 1'b0;
        wr_addr         = wslot_reg;
        wr_data.id      = id_reg;
        wr_data.lat     = lat_reg;
        wr_data.lon     = lon_reg;
        v1_next         = 1'b0;

        // distance pipeline advances every cycle
        v2_next    = v1_reg;
        v3_next    = v2_reg;
        v4_next    = v3_reg;
        v5_next    = v4_reg;
        idp2_next.lo = rd_a_reg.id;
        idp2_next.hi = rd_b_reg.id;
        idp3_next  = idp2_reg;
        idp4_next  = idp3_reg;
        idp5_next  = idp4_reg;
        dlat_next  = {rd_a_reg.lat[ptpa_pkg::LAT_W-1], rd_a_reg.lat}
                   - {rd_b_reg.lat[ptpa_pkg::LAT_W-1], rd_b_reg.lat};
        dlon_next  = {rd_a_reg.lon[ptpa_pkg::LON_W-1], rd_a_reg.lon}
                   - {rd_b_reg.lon[ptpa_pkg::LON_W-1], rd_b_reg.lon};
        mlat_next  = dlat_reg[31] ? (~dlat_reg + 32'd1) : dlat_reg;
        mlon_next  = dlon_reg[32] ? (~dlon_reg + 33'd1) : dlon_reg;
        clat_next  = (mlat_reg > 32'(cap_reg)) ? cap_reg : mlat_reg[ptpa_pkg::CAP_W-1:0];
        clon_next  = (mlon_reg > 33'(cap_reg)) ? cap_reg : mlon_reg[ptpa_pkg::CAP_W-1:0];
        sqlat_next = clat_reg * clat_reg;
        sqlon_next = clon_reg * clon_reg;

        unique case (state_reg)
            ptpa_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    id_next  = vehicle_id;
                    lat_next = latitude;
                    lon_next = longitude;
                    cap_next = {1'b0, radius_reg} + 1'b1;
                    lim_next = radius_reg * radius_reg;
                    pend_next.kind        = ptpa_pkg::KIND_STATUS;
                    pend_next.status      = ptpa_pkg::STATUS_DROPPED;
                    pend_next.low_battery = (battery < low_level_reg);
                    pend_next.first_id    = vehicle_id;
                    pend_next.second_id   = '0;
                    if (speed < min_speed_reg)
                    begin
                        strobe_next           = 1'b1;
                        out_next.kind         = ptpa_pkg::KIND_STATUS;
                        out_next.status       = ptpa_pkg::STATUS_FILTERED;
                        out_next.low_battery  = 1'b0;
                        out_next.first_id     = vehicle_id;
                        out_next.second_id    = '0;
                        last_next             = 1'b1;
                    end
                    else
                    begin
                        scan_next  = '0;
                        state_next = ptpa_pkg::ST_SEARCH;
                    end
                end
            end

            ptpa_pkg::ST_SEARCH:
            begin
                // issue one read a cycle, compare the one issued before
                if (scan_reg < count_reg)
                begin
                    addr_a       = scan_reg[SLOT_W-1:0];
                    chk_v_next   = 1'b1;
                    chk_idx_next = scan_reg[SLOT_W-1:0];
                    scan_next    = scan_reg + 1'b1;
                end
                if (chk_v_reg && id_match)
                begin
                    chk_v_next       = 1'b0;
                    wslot_next       = chk_idx_reg;
                    pend_next.status = ptpa_pkg::STATUS_UPDATED;
                    state_next       = ptpa_pkg::ST_WRITE;
                end
                else if (!chk_v_reg && scan_reg == count_reg)
                begin
                    if ({1'b0, count_reg} < SLOTS_C)
                    begin
                        wslot_next       = count_reg[SLOT_W-1:0];
                        pend_next.status = ptpa_pkg::STATUS_INSERTED;
                    end
                    else
                        pend_next.status = ptpa_pkg::STATUS_DROPPED;
                    state_next = ptpa_pkg::ST_WRITE;
                end
            end

            ptpa_pkg::ST_WRITE:
            begin
                wr_en = (pend_reg.status != ptpa_pkg::STATUS_DROPPED);
                if (pend_reg.status == ptpa_pkg::STATUS_INSERTED)
                    count_next = count_reg + 1'b1;
                pi_next         = '0;
                pj_next         = CNT_W'(1);
                issue_done_next = (count_next < CNT_W'(2));
                state_next      = ptpa_pkg::ST_PAIRS;
            end

            ptpa_pkg::ST_PAIRS:
            begin
                if (!issue_done_reg)
                begin
                    addr_a  = pi_reg[SLOT_W-1:0];
                    addr_b  = pj_reg[SLOT_W-1:0];
                    v1_next = 1'b1;
                    if (pj_inc < {1'b0, count_reg})
                        pj_next = pj_inc[CNT_W-1:0];
                    else if (pi_inc2 < {1'b0, count_reg})
                    begin
                        pi_next = pi_reg + 1'b1;
                        pj_next = pi_inc2[CNT_W-1:0];
                    end
                    else
                        issue_done_next = 1'b1;
                end
                // a close pair releases the held result and takes its place
                if (hit)
                begin
                    strobe_next           = 1'b1;
                    out_next              = pend_reg;
                    last_next             = 1'b0;
                    pend_next.kind        = ptpa_pkg::KIND_PAIR;
                    pend_next.status      = ptpa_pkg::STATUS_INSERTED;
                    pend_next.low_battery = 1'b0;
                    pend_next.first_id    = idp5_reg.lo;
                    pend_next.second_id   = idp5_reg.hi;
                end
                else if (issue_done_reg && !v1_reg && !v2_reg && !v3_reg && !v4_reg
                         && !v5_reg)
                begin
                    strobe_next = 1'b1;
                    out_next    = pend_reg;
                    last_next   = 1'b1;
                    state_next  = ptpa_pkg::ST_IDLE;
                end
            end

            default:
                state_next = ptpa_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ptpa_pkg::ST_IDLE;
            count_reg      <= '0;
            scan_reg       <= '0;
            chk_v_reg      <= 1'b0;
            issue_done_reg <= 1'b0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
            v4_reg         <= 1'b0;
            v5_reg         <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            scan_reg       <= scan_next;
            chk_v_reg      <= chk_v_next;
            issue_done_reg <= issue_done_next;
            v1_reg         <= v1_next;
            v2_reg         <= v2_next;
            v3_reg         <= v3_next;
            v4_reg         <= v4_next;
            v5_reg         <= v5_next;
            strobe_reg     <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg <= chk_idx_next;
        wslot_reg   <= wslot_next;
        pi_reg      <= pi_next;
        pj_reg      <= pj_next;
        id_reg      <= id_next;
        lat_reg     <= lat_next;
        lon_reg     <= lon_next;
        cap_reg     <= cap_next;
        lim_reg     <= lim_next;
        idp2_reg    <= idp2_next;
        idp3_reg    <= idp3_next;
        idp4_reg    <= idp4_next;
        idp5_reg    <= idp5_next;
        dlat_reg    <= dlat_next;
        dlon_reg    <= dlon_next;
        mlat_reg    <= mlat_next;
        mlon_reg    <= mlon_next;
        clat_reg    <= clat_next;
        clon_reg    <= clon_next;
        sqlat_reg   <= sqlat_next;
        sqlon_reg   <= sqlon_next;
        pend_reg    <= pend_next;
        out_reg     <= out_next;
        last_reg    <= last_next;
    end

    assign busy        = (state_reg != ptpa_pkg::ST_IDLE);
    assign strobe      = strobe_reg;
    assign result_kind = out_reg.kind;
    assign status      = out_reg.status;
    assign low_battery = out_reg.low_battery;
    assign first_id    = out_reg.first_id;
    assign second_id   = out_reg.second_id;
    assign last        = last_reg;

endmodule
